/* hw/rtl/rsp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsp_pkg: shared types and constants for the rectangle subtraction unit
// Coordinate widths, the input and result transaction structs, the
// per-stage pipeline records and the piece kind codes.
// ---------------------------------------------------------------------------
package rsp_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = 15;
    localparam int DIM_BITS   = 16;
    localparam int KIND_BITS  = 3;
    localparam int NUM_SLOTS  = 4;
    // Edge sums are held one bit wider than the widest operand.
    localparam int EDGE_BITS  = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

    localparam logic [KIND_BITS-1:0] KIND_WHOLE  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_TOP    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_BOTTOM = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_LEFT   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_RIGHT  = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic        [SIZE_BITS-1:0]  a_w;
        logic        [SIZE_BITS-1:0]  a_h;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic        [SIZE_BITS-1:0]  b_w;
        logic        [SIZE_BITS-1:0]  b_h;
    } rects_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] piece_x;
        logic signed [COORD_BITS-1:0] piece_y;
        logic        [DIM_BITS-1:0]   piece_w;
        logic        [DIM_BITS-1:0]   piece_h;
        logic        [KIND_BITS-1:0]  piece_kind;
        logic                         last_piece;
        logic                         no_piece;
    } piece_t;

    // Stage one: sign-extended edges of both rectangles.
    typedef struct packed {
        logic signed [EDGE_BITS-1:0] ax;
        logic signed [EDGE_BITS-1:0] ay;
        logic signed [EDGE_BITS-1:0] bx;
        logic signed [EDGE_BITS-1:0] by;
        logic signed [EDGE_BITS-1:0] ar;
        logic signed [EDGE_BITS-1:0] ab;
        logic signed [EDGE_BITS-1:0] br;
        logic signed [EDGE_BITS-1:0] bb;
        logic        [SIZE_BITS-1:0] aw;
        logic        [SIZE_BITS-1:0] ah;
    } edges_t;

    // Stage two: overlap rectangle and which pieces exist.
    typedef struct packed {
        logic signed [EDGE_BITS-1:0] ax;
        logic signed [EDGE_BITS-1:0] ay;
        logic signed [EDGE_BITS-1:0] ar;
        logic signed [EDGE_BITS-1:0] ab;
        logic signed [EDGE_BITS-1:0] l;
        logic signed [EDGE_BITS-1:0] t;
        logic signed [EDGE_BITS-1:0] r;
        logic signed [EDGE_BITS-1:0] bt;
        logic        [SIZE_BITS-1:0] aw;
        logic        [SIZE_BITS-1:0] ah;
        logic                        hit;
        logic                        has_top;
        logic                        has_bottom;
        logic                        has_left;
        logic                        has_right;
    } overlap_t;

    // Stage three: up to four finished pieces and a mask of those to send.
    typedef struct packed {
        piece_t [NUM_SLOTS-1:0] slots;
        logic   [NUM_SLOTS-1:0] mask;
    } job_t;

endpackage

/* hw/rtl/rsp_edges.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsp_edges: first pipeline stage
// Sign-extends the coordinates and forms the right and bottom edge sums.
// ---------------------------------------------------------------------------
module rsp_edges
    import rsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  rects_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output edges_t out_data
);

    logic   valid_reg;
    edges_t data_reg;
    edges_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.ax = {{(EDGE_BITS-COORD_BITS){in_data.a_x[COORD_BITS-1]}}, in_data.a_x};
        data_next.ay = {{(EDGE_BITS-COORD_BITS){in_data.a_y[COORD_BITS-1]}}, in_data.a_y};
        data_next.bx = {{(EDGE_BITS-COORD_BITS){in_data.b_x[COORD_BITS-1]}}, in_data.b_x};
        data_next.by = {{(EDGE_BITS-COORD_BITS){in_data.b_y[COORD_BITS-1]}}, in_data.b_y};
        data_next.aw = in_data.a_w;
        data_next.ah = in_data.a_h;
        data_next.ar = data_next.ax + $signed({{(EDGE_BITS-SIZE_BITS){1'b0}}, in_data.a_w});
        data_next.ab = data_next.ay + $signed({{(EDGE_BITS-SIZE_BITS){1'b0}}, in_data.a_h});
        data_next.br = data_next.bx + $signed({{(EDGE_BITS-SIZE_BITS){1'b0}}, in_data.b_w});
        data_next.bb = data_next.by + $signed({{(EDGE_BITS-SIZE_BITS){1'b0}}, in_data.b_h});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/rsp_overlap.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsp_overlap: second pipeline stage
// Finds the overlap edges by max and min and decides which pieces exist.
// ---------------------------------------------------------------------------
module rsp_overlap
    import rsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  edges_t   in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output overlap_t out_data
);

    logic     valid_reg;
    overlap_t data_reg;
    overlap_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.ax = in_data.ax;
        data_next.ay = in_data.ay;
        data_next.ar = in_data.ar;
        data_next.ab = in_data.ab;
        data_next.aw = in_data.aw;
        data_next.ah = in_data.ah;
        data_next.l  = (in_data.ax > in_data.bx) ? in_data.ax : in_data.bx;
        data_next.t  = (in_data.ay > in_data.by) ? in_data.ay : in_data.by;
        data_next.r  = (in_data.ar < in_data.br) ? in_data.ar : in_data.br;
        data_next.bt = (in_data.ab < in_data.bb) ? in_data.ab : in_data.bb;
        data_next.hit = (data_next.l < data_next.r) && (data_next.t < data_next.bt);
        // Each piece exists exactly when B's edge lies strictly inside A's.
        data_next.has_top    = in_data.by > in_data.ay;
        data_next.has_bottom = in_data.bb < in_data.ab;
        data_next.has_left   = in_data.bx > in_data.ax;
        data_next.has_right  = in_data.br < in_data.ar;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/rsp_pieces.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsp_pieces: third pipeline stage
// Builds the geometry of every candidate piece and the mask of pieces to send.
// ---------------------------------------------------------------------------
module rsp_pieces
    import rsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  overlap_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output job_t     out_data
);

    logic valid_reg;
    job_t data_reg;
    job_t data_next;

    logic signed [EDGE_BITS-1:0] top_h;
    logic signed [EDGE_BITS-1:0] bottom_h;
    logic signed [EDGE_BITS-1:0] left_w;
    logic signed [EDGE_BITS-1:0] right_w;
    logic signed [EDGE_BITS-1:0] mid_h;
    logic        [NUM_SLOTS-1:0] exist;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        top_h    = in_data.t - in_data.ay;
        bottom_h = in_data.ab - in_data.bt;
        left_w   = in_data.l - in_data.ax;
        right_w  = in_data.ar - in_data.r;
        mid_h    = in_data.bt - in_data.t;
        exist    = {in_data.has_right, in_data.has_left, in_data.has_bottom, in_data.has_top};

        data_next.slots[0] = '{in_data.ax[COORD_BITS-1:0], in_data.ay[COORD_BITS-1:0],
                               {1'b0, in_data.aw}, top_h[DIM_BITS-1:0],
                               KIND_TOP, 1'b0, 1'b0};
        data_next.slots[1] = '{in_data.ax[COORD_BITS-1:0], in_data.bt[COORD_BITS-1:0],
                               {1'b0, in_data.aw}, bottom_h[DIM_BITS-1:0],
                               KIND_BOTTOM, 1'b0, 1'b0};
        data_next.slots[2] = '{in_data.ax[COORD_BITS-1:0], in_data.t[COORD_BITS-1:0],
                               left_w[DIM_BITS-1:0], mid_h[DIM_BITS-1:0],
                               KIND_LEFT, 1'b0, 1'b0};
        data_next.slots[3] = '{in_data.r[COORD_BITS-1:0], in_data.t[COORD_BITS-1:0],
                               right_w[DIM_BITS-1:0], mid_h[DIM_BITS-1:0],
                               KIND_RIGHT, 1'b0, 1'b0};
        data_next.mask = exist;

        if (!in_data.hit)
        begin
            // No overlap: A goes out whole.
            data_next.slots[0] = '{in_data.ax[COORD_BITS-1:0], in_data.ay[COORD_BITS-1:0],
                                   {1'b0, in_data.aw}, {1'b0, in_data.ah},
                                   KIND_WHOLE, 1'b0, 1'b0};
            data_next.mask = {{(NUM_SLOTS-1){1'b0}}, 1'b1};
        end
        else if (exist == '0)
        begin
            // B covers A: a single empty marker closes the transaction.
            data_next.slots[0] = '{'0, '0, '0, '0, KIND_WHOLE, 1'b0, 1'b1};
            data_next.mask = {{(NUM_SLOTS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/rsp_emit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsp_emit: result serializer
// Holds one job and sends its pieces one per cycle through an output register.
// ---------------------------------------------------------------------------
module rsp_emit
    import rsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  job_t   in_data,
    output logic   piece_strobe,
    output piece_t piece
);

    piece_t [NUM_SLOTS-1:0] slots_reg;
    logic   [NUM_SLOTS-1:0] mask_reg;
    logic   [NUM_SLOTS-1:0] mask_rem;
    logic                   strobe_reg;
    piece_t                 piece_reg;
    piece_t                 piece_next;

    // Clearing the lowest set bit leaves the pieces still to go.
    assign mask_rem     = mask_reg & (mask_reg - {{(NUM_SLOTS-1){1'b0}}, 1'b1});
    assign in_ready     = (mask_rem == '0);
    assign piece_strobe = strobe_reg;
    assign piece        = piece_reg;

    always_comb
    begin
        if (mask_reg[0])
        begin
            piece_next = slots_reg[0];
        end
        else if (mask_reg[1])
        begin
            piece_next = slots_reg[1];
        end
        else if (mask_reg[2])
        begin
            piece_next = slots_reg[2];
        end
        else
        begin
            piece_next = slots_reg[3];
        end
        piece_next.last_piece = (mask_rem == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (mask_reg != '0);
            if (in_ready && in_valid)
            begin
                mask_reg <= in_data.mask;
            end
            else
            begin
                mask_reg <= mask_rem;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            slots_reg <= in_data.slots;
        end
        piece_reg <= piece_next;
    end

endmodule

/* hw/rtl/rect_subtract_pieces_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rect_subtract_pieces_unit: subtracts rectangle B from rectangle A
// Lists the parts of A outside B as up to four pieces per transaction.
// ---------------------------------------------------------------------------
// Usage. A transaction is offered on rects with start high; it is taken at
// a rising clock edge where start is high and busy is low. Each result
// piece appears on piece for exactly one cycle with piece_strobe high, and
// the receiver must take it in that cycle; it cannot stall the block.
// The pieces of one transaction leave in order top, bottom, left, right
// (only those that exist), or as one whole-A piece when there is no
// overlap, or as one empty marker (no_piece) when B covers A. The final
// piece of each transaction has last_piece set.
// The accepting edge loads the edge sums into the first stage register;
// the overlap min/max and compares, the piece geometry, the serializer
// load and the output register that drives piece_strobe follow in order.
// The serializer sends one piece per cycle and loads the next job while
// it sends the final piece of the current one, so a new transaction is
// accepted every cycle while each yields a single piece; transactions of
// several pieces hold it longer. busy rises when the pipeline is full
// behind a serializer that still has pieces to send.
// Reset empties all pipeline stages and the serializer; no strobe follows.
// ---------------------------------------------------------------------------
module rect_subtract_pieces_unit
    import rsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  rects_t rects,
    output logic   piece_strobe,
    output piece_t piece
);

    logic     edges_ready;
    logic     edges_valid;
    edges_t   edges_data;
    logic     overlap_ready;
    logic     overlap_valid;
    overlap_t overlap_data;
    logic     pieces_ready;
    logic     pieces_valid;
    job_t     pieces_data;
    logic     emit_ready;

    // busy follows only the stage-one hold condition, never start itself.
    assign busy = !edges_ready;

    rsp_edges u_edges (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_ready  (edges_ready),
        .in_data   (rects),
        .out_valid (edges_valid),
        .out_ready (overlap_ready),
        .out_data  (edges_data)
    );

    rsp_overlap u_overlap (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (edges_valid),
        .in_ready  (overlap_ready),
        .in_data   (edges_data),
        .out_valid (overlap_valid),
        .out_ready (pieces_ready),
        .out_data  (overlap_data)
    );

    rsp_pieces u_pieces (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (overlap_valid),
        .in_ready  (pieces_ready),
        .in_data   (overlap_data),
        .out_valid (pieces_valid),
        .out_ready (emit_ready),
        .out_data  (pieces_data)
    );

    rsp_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pieces_valid),
        .in_ready     (emit_ready),
        .in_data      (pieces_data),
        .piece_strobe (piece_strobe),
        .piece        (piece)
    );

`ifndef SYNTHESIS
    // The block can only hold off new work when stage one is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !edges_valid |-> !busy)
        else $error("busy raised with an empty first stage");

    // Pieces of one transaction leave back to back up to the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (piece_strobe && !piece.last_piece) |=> piece_strobe)
        else $error("gap inside a transaction's pieces");

    // The empty marker stands alone and carries no geometry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (piece_strobe && piece.no_piece) |->
        (piece.last_piece && piece.piece_w == '0 && piece.piece_h == '0
         && piece.piece_kind == KIND_WHOLE))
        else $error("malformed empty marker");

    // A whole-A piece is always the only piece of its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (piece_strobe && piece.piece_kind == KIND_WHOLE) |-> piece.last_piece)
        else $error("whole piece not flagged last");

    // Kind codes beyond the right piece are never produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_strobe |-> (piece.piece_kind <= KIND_RIGHT))
        else $error("unknown piece kind");
`endif

endmodule

/* tb/tb_rect_subtract_pieces_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rect_subtract_pieces_unit: self-checking bench for rectangle subtraction
// Sends pairs of rectangles through the command interface and checks every
// piece strobe against an in-bench prediction. A typed table of corner cases
// comes first, then random pairs under several sender idling phases.
// ---------------------------------------------------------------------------
module tb_rect_subtract_pieces_unit;
    import rsp_pkg::*;

    // Clock, reset and the ports of the block.
    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    rects_t rects;
    logic   piece_strobe;
    piece_t piece;

    // One row of the directed table. When want_typed is set, the expected
    // piece is written out by hand and the row yields exactly that one
    // piece; otherwise the pieces come from the predictor below.
    typedef struct {
        rects_t pair;
        bit     want_typed;
        piece_t want;
    } pair_row_t;

    pair_row_t directed_rows[$];

    // Pieces still owed by the block, oldest first.
    piece_t expected_pieces[$];

    int fault_count      = 0;
    int pairs_sent       = 0;
    int pieces_checked   = 0;
    int covered_markers  = 0;
    int four_piece_pairs = 0;

    // Sender idling per phase, in percent of transactions. The receiver
    // cannot stall this block, so only the sender side idles.
    int idle_pct_by_phase[3] = '{0, 62, 7};

    rect_subtract_pieces_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .rects        (rects),
        .piece_strobe (piece_strobe),
        .piece        (piece)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog. The slowest correct run is well under 0.1 ms, so 2 ms
    // only trips on a hang.
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Packs signed coordinates and sizes into the input struct. Coordinates
    // wrap to 16 bits, which lets random offsets run off either end.
    function automatic rects_t mk_rects(input int ax, input int ay, input int aw,
                                        input int ah, input int bx, input int by,
                                        input int bw, input int bh);
        rects_t r;
        r.a_x = COORD_BITS'(ax);
        r.a_y = COORD_BITS'(ay);
        r.a_w = SIZE_BITS'(aw);
        r.a_h = SIZE_BITS'(ah);
        r.b_x = COORD_BITS'(bx);
        r.b_y = COORD_BITS'(by);
        r.b_w = SIZE_BITS'(bw);
        r.b_h = SIZE_BITS'(bh);
        return r;
    endfunction

    // The piece position keeps only its low 16 bits, so a bottom or right
    // edge past +32767 wraps in two's complement just as in the block.
    function automatic piece_t mk_piece(input int x, input int y, input int w,
                                        input int h, input logic [KIND_BITS-1:0] kind,
                                        input bit last, input bit none);
        piece_t p;
        p.piece_x    = COORD_BITS'(x);
        p.piece_y    = COORD_BITS'(y);
        p.piece_w    = DIM_BITS'(w);
        p.piece_h    = DIM_BITS'(h);
        p.piece_kind = kind;
        p.last_piece = last;
        p.no_piece   = none;
        return p;
    endfunction

    // Appends one piece to the list of pieces owed by the block.
    function automatic void owe_piece(input piece_t p);
        expected_pieces.insert(expected_pieces.size(), p);
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input rects_t pair, input bit want_typed,
                                    input piece_t want);
        pair_row_t row;
        row.pair       = pair;
        row.want_typed = want_typed;
        row.want       = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Works out the pieces of A outside B and queues them. All edge math
    // runs in 32-bit integers, wide enough that no sum can overflow.
    function automatic void predict_pieces(input rects_t r);
        int     ax, ay, aw, ah, bx, by, bw, bh;
        int     a_right, a_bottom, b_right, b_bottom;
        int     ov_left, ov_top, ov_right, ov_bottom;
        piece_t found[$];
        ax = $signed(r.a_x);
        ay = $signed(r.a_y);
        aw = r.a_w;
        ah = r.a_h;
        bx = $signed(r.b_x);
        by = $signed(r.b_y);
        bw = r.b_w;
        bh = r.b_h;
        a_right  = ax + aw;
        a_bottom = ay + ah;
        b_right  = bx + bw;
        b_bottom = by + bh;
        ov_left   = (ax > bx) ? ax : bx;
        ov_top    = (ay > by) ? ay : by;
        ov_right  = (a_right < b_right) ? a_right : b_right;
        ov_bottom = (a_bottom < b_bottom) ? a_bottom : b_bottom;

        // The overlap test is strict: touching edges or an empty rectangle
        // leave A untouched.
        if (!(ov_left < ov_right && ov_top < ov_bottom))
        begin
            found.insert(found.size(),
                         mk_piece(ax, ay, aw, ah, KIND_WHOLE, 1'b0, 1'b0));
        end
        else
        begin
            // Top and bottom span the full width of A; left and right only
            // cover the rows of the overlap.
            if (ov_top > ay)
                found.insert(found.size(),
                             mk_piece(ax, ay, aw, ov_top - ay, KIND_TOP, 1'b0, 1'b0));
            if (ov_bottom < a_bottom)
                found.insert(found.size(),
                             mk_piece(ax, ov_bottom, aw, a_bottom - ov_bottom,
                                      KIND_BOTTOM, 1'b0, 1'b0));
            if (ov_left > ax)
                found.insert(found.size(),
                             mk_piece(ax, ov_top, ov_left - ax, ov_bottom - ov_top,
                                      KIND_LEFT, 1'b0, 1'b0));
            if (ov_right < a_right)
                found.insert(found.size(),
                             mk_piece(ov_right, ov_top, a_right - ov_right,
                                      ov_bottom - ov_top, KIND_RIGHT, 1'b0, 1'b0));
            // B covers A: a single empty marker still closes the transaction.
            if (found.size() == 0)
                found.insert(found.size(),
                             mk_piece(0, 0, 0, 0, KIND_WHOLE, 1'b0, 1'b1));
        end
        if (found.size() == 4)
            four_piece_pairs++;
        found[found.size() - 1].last_piece = 1'b1;
        foreach (found[i])
            owe_piece(found[i]);
    endfunction

    // Random pairs. Most have B placed around A so that the overlap and all
    // piece combinations show up; some are raw bits so that every input bit
    // toggles, some make B cover A, and some sit near the top of the
    // coordinate range so that bottom and right edges wrap.
    function automatic rects_t random_rects();
        int           mode, ax, ay, aw, ah, bx, by, bw, bh;
        logic [127:0] raw;
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom()};
            return raw[$bits(rects_t)-1:0];
        end
        if ($urandom_range(0, 7) == 0)
        begin
            aw = $urandom_range(0, 32767);
            ah = $urandom_range(0, 32767);
        end
        else
        begin
            aw = $urandom_range(1, 3000);
            ah = $urandom_range(1, 3000);
        end
        ax = int'($urandom_range(0, 40000)) - 20000;
        ay = int'($urandom_range(0, 40000)) - 20000;
        if (mode == 8)
        begin
            bx = ax - int'($urandom_range(0, 50));
            by = ay - int'($urandom_range(0, 50));
            bw = aw + (ax - bx) + int'($urandom_range(0, 50));
            bh = ah + (ay - by) + int'($urandom_range(0, 50));
        end
        else if (mode == 9)
        begin
            ax = 32767 - int'($urandom_range(100, 600));
            ay = 32767 - int'($urandom_range(100, 600));
            aw = $urandom_range(20000, 32767);
            ah = $urandom_range(20000, 32767);
            bx = ax + int'($urandom_range(0, 99));
            by = ay + int'($urandom_range(0, 99));
            bw = $urandom_range(0, 2000);
            bh = $urandom_range(0, 2000);
        end
        else
        begin
            bx = ax + int'($urandom_range(0, aw + 200)) - 100;
            by = ay + int'($urandom_range(0, ah + 200)) - 100;
            bw = $urandom_range(0, aw + 200);
            bh = $urandom_range(0, ah + 200);
        end
        if (bw > 32767)
            bw = 32767;
        if (bh > 32767)
            bh = 32767;
        return mk_rects(ax, ay, aw, ah, bx, by, bw, bh);
    endfunction

    // Offers one transaction from a falling edge and holds it until a rising
    // edge sees busy low. The expectations are queued at that edge, which is
    // well ahead of the first piece strobe. Returns at the next falling edge
    // without touching start, so a follow-on transaction keeps start high.
    task automatic send_rects(input rects_t r, input bit want_typed, input piece_t want);
        start <= 1'b1;
        rects <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (want_typed)
            owe_piece(want);
        else
            predict_pieces(r);
        pairs_sent++;
        @(negedge clk);
    endtask

    // Drops start for a number of cycles; called at a falling edge.
    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    // Every strobe must match the oldest owed piece, field by field. The
    // receiver has no way to push back, so each strobe is taken as it comes.
    always @(posedge clk)
    begin : check_pieces
        piece_t want;
        if (rst_n && piece_strobe)
        begin
            if (expected_pieces.size() == 0)
            begin
                $error("piece strobe with no piece owed: x %0d y %0d kind %0d",
                       $signed(piece.piece_x), $signed(piece.piece_y), piece.piece_kind);
                fault_count++;
            end
            else
            begin
                want = expected_pieces.pop_front();
                compare_field("piece_x", $signed(want.piece_x), $signed(piece.piece_x));
                compare_field("piece_y", $signed(want.piece_y), $signed(piece.piece_y));
                compare_field("piece_w", want.piece_w, piece.piece_w);
                compare_field("piece_h", want.piece_h, piece.piece_h);
                compare_field("piece_kind", want.piece_kind, piece.piece_kind);
                compare_field("last_piece", want.last_piece, piece.last_piece);
                compare_field("no_piece", want.no_piece, piece.no_piece);
                pieces_checked++;
                if (want.no_piece)
                    covered_markers++;
            end
        end
    end

    initial
    begin : run_stimulus
        int     drain_cycles;
        int     idle_pct;
        piece_t no_want;
        // All inputs known from time zero; reset held low until the table is built.
        rst_n   = 1'b0;
        start   = 1'b0;
        rects   = '0;
        no_want = '0;

        // Directed table. Single-piece outcomes that are obvious from the
        // inputs carry their expected piece; the rest go to the predictor.
        // Empty A, zero width and then zero height: A comes back whole.
        add_row(mk_rects(0, 0, 0, 10, 0, 0, 10, 10), 1'b1,
                mk_piece(0, 0, 0, 10, KIND_WHOLE, 1'b1, 1'b0));
        add_row(mk_rects(5, 7, 10, 0, 0, 0, 20, 20), 1'b1,
                mk_piece(5, 7, 10, 0, KIND_WHOLE, 1'b1, 1'b0));
        // Empty B inside A: no overlap.
        add_row(mk_rects(0, 0, 10, 10, 3, 3, 0, 4), 1'b1,
                mk_piece(0, 0, 10, 10, KIND_WHOLE, 1'b1, 1'b0));
        // B touching A on its right edge: the strict test finds no overlap.
        add_row(mk_rects(0, 0, 10, 10, 10, 0, 10, 10), 1'b1,
                mk_piece(0, 0, 10, 10, KIND_WHOLE, 1'b1, 1'b0));
        // Opposite corners of the coordinate range, full sizes.
        add_row(mk_rects(-32768, -32768, 32767, 32767,
                         32767, 32767, 32767, 32767), 1'b1,
                mk_piece(-32768, -32768, 32767, 32767,
                         KIND_WHOLE, 1'b1, 1'b0));
        // B covers A: a lone empty marker, in several shapes.
        add_row(mk_rects(10, 10, 5, 5, 0, 0, 100, 100), 1'b1,
                mk_piece(0, 0, 0, 0, KIND_WHOLE, 1'b1, 1'b1));
        add_row(mk_rects(-5, -5, 10, 10, -5, -5, 10, 10), 1'b1,
                mk_piece(0, 0, 0, 0, KIND_WHOLE, 1'b1, 1'b1));
        add_row(mk_rects(0, 0, 1, 1, 0, 0, 1, 1), 1'b1,
                mk_piece(0, 0, 0, 0, KIND_WHOLE, 1'b1, 1'b1));
        add_row(mk_rects(-100, -100, 50, 50,
                         -32768, -32768, 32767, 32767), 1'b1,
                mk_piece(0, 0, 0, 0, KIND_WHOLE, 1'b1, 1'b1));
        add_row(mk_rects(-1, -1, 32767, 32767, -1, -1, 32767, 32767),
                1'b1, mk_piece(0, 0, 0, 0, KIND_WHOLE, 1'b1, 1'b1));
        add_row(mk_rects(32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767), 1'b1,
                mk_piece(0, 0, 0, 0, KIND_WHOLE, 1'b1, 1'b1));
        // Each piece kind on its own, then the pairs and a corner bite.
        add_row(mk_rects(0, 0, 10, 10, 0, 5, 10, 10), 1'b0, no_want);
        add_row(mk_rects(0, 0, 10, 10, 0, -5, 10, 10), 1'b0, no_want);
        add_row(mk_rects(0, 0, 10, 10, 5, 0, 10, 10), 1'b0, no_want);
        add_row(mk_rects(0, 0, 10, 10, -5, 0, 10, 10), 1'b0, no_want);
        add_row(mk_rects(0, 0, 10, 10, 3, -1, 4, 20), 1'b0, no_want);
        add_row(mk_rects(0, 0, 10, 10, -1, 3, 20, 4), 1'b0, no_want);
        add_row(mk_rects(0, 0, 10, 10, 5, 5, 10, 10), 1'b0, no_want);
        // Largest A with a hole in the middle: all four pieces.
        add_row(mk_rects(-32768, -32768, 32767, 32767,
                         -20000, -20000, 100, 100), 1'b0, no_want);
        // Right and bottom edges past +32767, so those positions wrap.
        add_row(mk_rects(32000, 0, 32767, 10, 32700, 0, 200, 10),
                1'b0, no_want);
        add_row(mk_rects(0, 32000, 10, 32767, 0, 32700, 10, 200),
                1'b0, no_want);
        add_row(mk_rects(32000, 32000, 32767, 32767,
                         32100, 32100, 1000, 1000), 1'b0, no_want);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed rows go in back to back with the odd short gap, so that
        // multi-piece rows also run into busy.
        foreach (directed_rows[i])
        begin
            send_rects(directed_rows[i].pair, directed_rows[i].want_typed,
                       directed_rows[i].want);
            if ($urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 3));
        end

        // Random part. The idling phase changes every 40 transactions, so
        // the gaps land on every step of the serializer and there are long
        // stretches with start held high throughout.
        for (int n = 0; n < 460; n++)
        begin
            idle_pct = idle_pct_by_phase[(n / 40) % 3];
            send_rects(random_rects(), 1'b0, no_want);
            if (int'($urandom_range(0, 99)) < idle_pct)
                idle_sender($urandom_range(1, 6));
        end
        start <= 1'b0;

        // Let every owed piece arrive, then keep watching for stray strobes.
        drain_cycles = 0;
        while (expected_pieces.size() != 0 && drain_cycles < 2000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20) @(posedge clk);
        if (expected_pieces.size() != 0)
        begin
            $error("%0d pieces never arrived", expected_pieces.size());
            fault_count++;
        end

        $display("Sent %0d rectangle pairs and checked %0d pieces, %0d of them empty markers.",
                 pairs_sent, pieces_checked, covered_markers);
        $display("%0d pairs split into four pieces; %0d faults seen.",
                 four_piece_pairs, fault_count);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
